// ===== rtl/fzpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fzpc_pkg
// Shared types, widths and codes for the forbidden zone polygon check core.
// ----------------------------------------------------------------------------
package fzpc_pkg;

   // default table sizes
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_ZONES_DEF    = 8;

   // field widths
   localparam int KIND_W = 2;
   localparam int AZ_W   = 16;
   localparam int EL_W   = 15;
   localparam int IDX_W  = 3;

   // width of one cross product
   localparam int PROD_W = AZ_W + EL_W + 2;

   // item kinds; the fourth code means nothing
   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2
   } kind_type;

   // result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // control states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QUERY,
      ST_FINISH
   } state_type;

   // one stored vertex, closes marks the last vertex of a zone
   typedef struct packed {
      logic                   closes;
      logic signed [EL_W-1:0] el;
      logic [AZ_W-1:0]        az;
   } vertex_type;

   // one edge handed to the edge test unit
   typedef struct packed {
      logic       valid;
      logic       last;
      vertex_type a;
      vertex_type b;
   } edge_type;

   // edge test outcome and pipeline occupancy
   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
      logic busy;
   } cross_type;

endpackage

// ===== rtl/fzpc_ifs.sv =====
// ----------------------------------------------------------------------------
// fzpc_ifs
// Valid/ready channels for query and load items and for their results.
// ----------------------------------------------------------------------------
interface fzpc_req_if;
   logic                                valid;
   logic                                ready;
   logic [fzpc_pkg::KIND_W-1:0]         kind;
   logic [fzpc_pkg::AZ_W-1:0]           azimuth;
   logic signed [fzpc_pkg::EL_W-1:0]    elevation;
   logic                                closes_zone;

   modport source (output valid, kind, azimuth, elevation, closes_zone, input ready);
   modport sink   (input valid, kind, azimuth, elevation, closes_zone, output ready);
endinterface

interface fzpc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         in_zone;
   logic [fzpc_pkg::IDX_W-1:0]   zone_index;
   logic                         status;

   modport source (output valid, in_zone, zone_index, status, input ready);
   modport sink   (input valid, in_zone, zone_index, status, output ready);
endinterface

// ===== rtl/fzpc_ram.sv =====
// ----------------------------------------------------------------------------
// fzpc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fzpc_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fzpc_edge_unit.sv =====
// ----------------------------------------------------------------------------
// fzpc_edge_unit
// Pipelined even-odd ray crossing test of one polygon edge per cycle.
// ----------------------------------------------------------------------------
module fzpc_edge_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              flush,
   input  logic [fzpc_pkg::AZ_W-1:0]         p_az,
   input  logic signed [fzpc_pkg::EL_W-1:0]  p_el,
   input  fzpc_pkg::edge_type                edge_in,
   output fzpc_pkg::cross_type               cross_out
);

   localparam int AZ_W   = fzpc_pkg::AZ_W;
   localparam int EL_W   = fzpc_pkg::EL_W;
   localparam int PROD_W = fzpc_pkg::PROD_W;

   // stage 1: side test and differences
   logic                 e1_valid_ff, e1_valid_in;
   logic                 e1_last_ff;
   logic                 e1_side_ff, e1_side_in;
   logic signed [AZ_W:0] e1_dx_ff, e1_dx_in;
   logic signed [AZ_W:0] e1_ax_ff, e1_ax_in;
   logic signed [EL_W:0] e1_d_ff, e1_d_in;
   logic signed [EL_W:0] e1_dy_ff, e1_dy_in;

   // stage 2: cross products
   logic                     e2_valid_ff, e2_valid_in;
   logic                     e2_last_ff;
   logic                     e2_side_ff;
   logic                     e2_dneg_ff;
   logic signed [PROD_W-1:0] e2_lhs_ff;
   logic signed [PROD_W-1:0] e2_rhs_ff;

   logic cross_hit;

   always_comb begin
      e1_valid_in = edge_in.valid && !flush;
      e1_side_in  = (edge_in.a.el > p_el) != (edge_in.b.el > p_el);
      e1_dx_in    = {1'b0, p_az} - {1'b0, edge_in.a.az};
      e1_ax_in    = {1'b0, edge_in.b.az} - {1'b0, edge_in.a.az};
      e1_d_in     = {edge_in.b.el[EL_W-1], edge_in.b.el}
                  - {edge_in.a.el[EL_W-1], edge_in.a.el};
      e1_dy_in    = {p_el[EL_W-1], p_el} - {edge_in.a.el[EL_W-1], edge_in.a.el};
      e2_valid_in = e1_valid_ff && !flush;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= e1_valid_in;
         e2_valid_ff <= e2_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      e1_last_ff <= edge_in.last;
      e1_side_ff <= e1_side_in;
      e1_dx_ff   <= e1_dx_in;
      e1_ax_ff   <= e1_ax_in;
      e1_d_ff    <= e1_d_in;
      e1_dy_ff   <= e1_dy_in;
      e2_last_ff <= e1_last_ff;
      e2_side_ff <= e1_side_ff;
      e2_dneg_ff <= e1_d_ff[EL_W];
      e2_lhs_ff  <= e1_dx_ff * e1_d_ff;
      e2_rhs_ff  <= e1_ax_ff * e1_dy_ff;
   end

   // point lies left of the crossing, compare flips for a falling edge
   always_comb begin
      if (e2_dneg_ff) begin
         cross_hit = e2_side_ff && (e2_lhs_ff > e2_rhs_ff);
      end else begin
         cross_hit = e2_side_ff && (e2_lhs_ff < e2_rhs_ff);
      end
   end

   assign cross_out.valid = e2_valid_ff;
   assign cross_out.last  = e2_last_ff;
   assign cross_out.hit   = cross_hit;
   assign cross_out.busy  = e1_valid_ff || e2_valid_ff;

endmodule

// ===== rtl/forbidden_zone_polygon_check_core.sv =====
// ----------------------------------------------------------------------------
// forbidden_zone_polygon_check_core
// Forbidden zone table with even-odd point in polygon test over stored edges.
// ----------------------------------------------------------------------------
// every item leaves its result in a holding register, which is loaded into
// the output register once that is free; a query reads the vertices of the
// closed zones in order and ends on the first zone whose last edge shows the
// point inside, else once the walk and the edge unit are empty
// one item at a time; a new item is taken while a result waits
// reset: tables empty at once, vertex RAM contents are not cleared
module forbidden_zone_polygon_check_core #(
   parameter int MAX_VERTICES = fzpc_pkg::MAX_VERTICES_DEF,
   parameter int MAX_ZONES    = fzpc_pkg::MAX_ZONES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fzpc_req_if.sink   req_ch,
   fzpc_rsp_if.source rsp_ch
);

   localparam int VAW   = $clog2(MAX_VERTICES);
   localparam int VCW   = $clog2(MAX_VERTICES + 1);
   localparam int ZCW   = $clog2(MAX_ZONES + 1);
   localparam int IDX_W = fzpc_pkg::IDX_W;
   localparam int AZ_W  = fzpc_pkg::AZ_W;
   localparam int EL_W  = fzpc_pkg::EL_W;
   localparam int VTX_W = $bits(fzpc_pkg::vertex_type);

   // control state
   fzpc_pkg::state_type state_ff, state_in;
   logic [VCW-1:0] vcount_ff, vcount_in;
   logic [ZCW-1:0] zcount_ff, zcount_in;
   logic [VCW-1:0] open_start_ff, open_start_in;

   // query point
   logic [AZ_W-1:0]        p_az_ff, p_az_in;
   logic signed [EL_W-1:0] p_el_ff, p_el_in;

   // pending result and output register
   logic             res_hit_ff, res_hit_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic             rsp_status_ff, rsp_status_in;

   // vertex walk
   logic [VCW-1:0]       rd_addr_ff, rd_addr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 is_first_ff, is_first_in;
   logic                 wrap_pend_ff, wrap_pend_in;
   logic                 parity_ff, parity_in;
   logic [ZCW-1:0]       zone_cnt_ff, zone_cnt_in;
   fzpc_pkg::vertex_type first_vtx_ff, first_vtx_in;
   fzpc_pkg::vertex_type prev_vtx_ff, prev_vtx_in;
   fzpc_pkg::vertex_type wrap_a_ff, wrap_a_in;
   fzpc_pkg::vertex_type wrap_b_ff, wrap_b_in;

   // RAM and edge unit hookup
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [VTX_W-1:0]     ram_rd_data;
   fzpc_pkg::vertex_type new_vtx;
   fzpc_pkg::vertex_type cur_vtx;
   fzpc_pkg::edge_type   edge_sel;
   fzpc_pkg::cross_type  cross_res;

   logic accept;
   logic in_query;
   logic table_full;
   logic load_rsp;
   logic walk_done;

   assign accept     = req_ch.valid && req_ch.ready;
   assign in_query   = (state_ff == fzpc_pkg::ST_QUERY);
   assign table_full = (vcount_ff >= VCW'(MAX_VERTICES)) || (zcount_ff >= ZCW'(MAX_ZONES));
   assign cur_vtx    = fzpc_pkg::vertex_type'(ram_rd_data);

   assign new_vtx.closes = req_ch.closes_zone;
   assign new_vtx.el     = req_ch.elevation;
   assign new_vtx.az     = req_ch.azimuth;

   // vertex store; appends happen only while idle and the walk only while
   // querying, so a write and a read never meet at one entry
   fzpc_ram #(
      .WIDTH (VTX_W),
      .DEPTH (MAX_VERTICES)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (vcount_ff[VAW-1:0]),
      .wr_data (new_vtx),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff[VAW-1:0]),
      .rd_data (ram_rd_data)
   );

   // the vertex after a closing vertex starts a zone and makes no edge,
   // so the wrap edge takes that slot
   always_comb begin
      edge_sel.a = prev_vtx_ff;
      edge_sel.b = cur_vtx;
      edge_sel.last  = 1'b0;
      edge_sel.valid = in_query && rd_valid_ff && !is_first_ff;
      if (wrap_pend_ff) begin
         edge_sel.a     = wrap_a_ff;
         edge_sel.b     = wrap_b_ff;
         edge_sel.last  = 1'b1;
         edge_sel.valid = in_query;
      end
   end

   fzpc_edge_unit u_edge (
      .clock     (clock),
      .reset     (reset),
      .flush     (!in_query),
      .p_az      (p_az_ff),
      .p_el      (p_el_ff),
      .edge_in   (edge_sel),
      .cross_out (cross_res)
   );

   assign walk_done = (rd_addr_ff == open_start_ff) && !rd_valid_ff && !wrap_pend_ff
                    && !cross_res.busy;
   assign load_rsp  = (state_ff == fzpc_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      vcount_in     = vcount_ff;
      zcount_in     = zcount_ff;
      open_start_in = open_start_ff;
      p_az_in       = p_az_ff;
      p_el_in       = p_el_ff;
      res_hit_in    = res_hit_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      rd_addr_in    = rd_addr_ff;
      rd_valid_in   = 1'b0;
      is_first_in   = is_first_ff;
      wrap_pend_in  = 1'b0;
      parity_in     = parity_ff;
      zone_cnt_in   = zone_cnt_ff;
      first_vtx_in  = first_vtx_ff;
      prev_vtx_in   = prev_vtx_ff;
      wrap_a_in     = wrap_a_ff;
      wrap_b_in     = wrap_b_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         fzpc_pkg::ST_IDLE: begin
            if (accept) begin
               res_hit_in    = 1'b0;
               res_idx_in    = '0;
               res_status_in = fzpc_pkg::STATUS_OK;
               state_in      = fzpc_pkg::ST_FINISH;
               unique case (fzpc_pkg::kind_type'(req_ch.kind))
                  fzpc_pkg::KIND_CLEAR: begin
                     vcount_in     = '0;
                     zcount_in     = '0;
                     open_start_in = '0;
                  end
                  fzpc_pkg::KIND_APPEND: begin
                     if (table_full) begin
                        res_status_in = fzpc_pkg::STATUS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        vcount_in = vcount_ff + 1'b1;
                        if (req_ch.closes_zone) begin
                           zcount_in     = zcount_ff + 1'b1;
                           open_start_in = vcount_ff + 1'b1;
                        end
                     end
                  end
                  fzpc_pkg::KIND_QUERY: begin
                     p_az_in     = req_ch.azimuth;
                     p_el_in     = req_ch.elevation;
                     rd_addr_in  = '0;
                     is_first_in = 1'b1;
                     parity_in   = 1'b0;
                     zone_cnt_in = '0;
                     state_in    = fzpc_pkg::ST_QUERY;
                  end
                  default: begin
                  end
               endcase
            end
         end

         fzpc_pkg::ST_QUERY: begin
            // issue one vertex read per cycle over the closed zones
            if (rd_addr_ff < open_start_ff) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = 1'b1;
               rd_addr_in  = rd_addr_ff + 1'b1;
            end
            // vertex arrives: track zone start, previous vertex, wrap edge
            if (rd_valid_ff) begin
               prev_vtx_in  = cur_vtx;
               is_first_in  = cur_vtx.closes;
               wrap_pend_in = cur_vtx.closes;
               wrap_a_in    = cur_vtx;
               wrap_b_in    = is_first_ff ? cur_vtx : first_vtx_ff;
               if (is_first_ff) begin
                  first_vtx_in = cur_vtx;
               end
            end
            // crossing parity per zone
            if (cross_res.valid) begin
               if (cross_res.last) begin
                  parity_in   = 1'b0;
                  zone_cnt_in = zone_cnt_ff + 1'b1;
               end else begin
                  parity_in = parity_ff ^ cross_res.hit;
               end
            end
            if (cross_res.valid && cross_res.last && (parity_ff ^ cross_res.hit)) begin
               res_hit_in = 1'b1;
               res_idx_in = IDX_W'(zone_cnt_ff);
               state_in   = fzpc_pkg::ST_FINISH;
            end else if (walk_done) begin
               res_hit_in = 1'b0;
               res_idx_in = '0;
               state_in   = fzpc_pkg::ST_FINISH;
            end
         end

         fzpc_pkg::ST_FINISH: begin
            if (load_rsp) begin
               state_in = fzpc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fzpc_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_hit_in    = res_hit_ff;
         rsp_idx_in    = res_idx_ff;
         rsp_status_in = res_status_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fzpc_pkg::ST_IDLE;
         vcount_ff     <= '0;
         zcount_ff     <= '0;
         open_start_ff <= '0;
         rd_valid_ff   <= 1'b0;
         wrap_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vcount_ff     <= vcount_in;
         zcount_ff     <= zcount_in;
         open_start_ff <= open_start_in;
         rd_valid_ff   <= rd_valid_in;
         wrap_pend_ff  <= wrap_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      p_az_ff       <= p_az_in;
      p_el_ff       <= p_el_in;
      res_hit_ff    <= res_hit_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rd_addr_ff    <= rd_addr_in;
      is_first_ff   <= is_first_in;
      parity_ff     <= parity_in;
      zone_cnt_ff   <= zone_cnt_in;
      first_vtx_ff  <= first_vtx_in;
      prev_vtx_ff   <= prev_vtx_in;
      wrap_a_ff     <= wrap_a_in;
      wrap_b_ff     <= wrap_b_in;
   end

   assign req_ch.ready      = (state_ff == fzpc_pkg::ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.in_zone    = rsp_hit_ff;
   assign rsp_ch.zone_index = rsp_idx_ff;
   assign rsp_ch.status     = rsp_status_ff;

endmodule

// ===== rtl/fzpc_check.sv =====
// ----------------------------------------------------------------------------
// fzpc_check
// Port level checks for the forbidden zone polygon check core.
// ----------------------------------------------------------------------------
module fzpc_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_in_zone,
   input logic [fzpc_pkg::IDX_W-1:0]   rsp_zone_index,
   input logic                         rsp_status
);

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // a waiting result keeps its fields
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_in_zone, rsp_zone_index, rsp_status}))
      else $error("result fields changed while stalled");

   // one item at a time: ready drops after an accepted item
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   // a miss reports zone zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_zone |-> rsp_zone_index == '0)
      else $error("zone index set without a match");

   // an ignored load never reports a match
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_in_zone)
      else $error("table full status together with a match");

endmodule

bind forbidden_zone_polygon_check_core fzpc_check u_fzpc_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_in_zone    (rsp_ch.in_zone),
   .rsp_zone_index (rsp_ch.zone_index),
   .rsp_status     (rsp_ch.status)
);
